>>> rtl/gne_pkg.sv
// Shared types and constants for the grid neighbor expander.
package gne_pkg;

  // Field widths of the stream items
  localparam int IDX_W   = 16;
  localparam int VAL_W   = 8;
  localparam int COORD_W = 8;
  localparam int DIR_W   = 3;
  localparam int DIST_W  = 25;
  localparam int COST_W  = 17;
  localparam int SIZE_W  = 24;
  localparam int SIDE_W  = 9;
  localparam int MAPS_W  = 3;

  // Item modes
  localparam logic [1:0] MODE_LOAD_OCC  = 2'd0;
  localparam logic [1:0] MODE_LOAD_COST = 2'd1;
  localparam logic [1:0] MODE_EXPAND    = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_OCCUPIED_MIN  = 3'd2;
  localparam logic [2:0] REG_OCCUPIED_MAX  = 3'd3;
  localparam logic [2:0] REG_CELL_SIZE     = 3'd4;
  localparam logic [2:0] REG_ACTIVE_MAPS   = 3'd5;

  // Direction masks, bit d set when direction d moves that way
  localparam logic [7:0] DIR_LEFT     = 8'b0010_1001;
  localparam logic [7:0] DIR_RIGHT    = 8'b1001_0100;
  localparam logic [7:0] DIR_UP       = 8'b0000_0111;
  localparam logic [7:0] DIR_DOWN     = 8'b1110_0000;
  localparam logic [7:0] DIR_STRAIGHT = 8'b0101_1010;

  // sqrt(2) in Q30
  localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

  // Cost divide: q = (num * ceil(2^39 / (255*n))) >> 39, exact for num < 2^27
  localparam int COST_SHIFT = 39;
  localparam int SUM_W      = 11;
  localparam int NUM_W      = 27;
  localparam int RECIP_W    = 32;
  localparam int NMAP_W     = 4;
  localparam logic [63:0] RECIP_ONE = 64'd1 << COST_SHIFT;
  localparam logic [RECIP_W-1:0] COST_RECIP [0:8] = '{
    32'd0,
    32'((RECIP_ONE + 64'd255 * 1 - 64'd1) / (64'd255 * 1)),
    32'((RECIP_ONE + 64'd255 * 2 - 64'd1) / (64'd255 * 2)),
    32'((RECIP_ONE + 64'd255 * 3 - 64'd1) / (64'd255 * 3)),
    32'((RECIP_ONE + 64'd255 * 4 - 64'd1) / (64'd255 * 4)),
    32'((RECIP_ONE + 64'd255 * 5 - 64'd1) / (64'd255 * 5)),
    32'((RECIP_ONE + 64'd255 * 6 - 64'd1) / (64'd255 * 6)),
    32'((RECIP_ONE + 64'd255 * 7 - 64'd1) / (64'd255 * 7)),
    32'((RECIP_ONE + 64'd255 * 8 - 64'd1) / (64'd255 * 8))
  };

  // Output queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int FIFO_CW    = 5;

  // One result item
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   neighbor_index;
    logic [COORD_W-1:0] neighbor_x;
    logic [COORD_W-1:0] neighbor_y;
    logic [DIR_W-1:0]   direction;
    logic [DIST_W-1:0]  distance_q16;
    logic [COST_W-1:0]  cost_q16;
    logic               last;
  } result_t;

endpackage

>>> rtl/grid_neighbor_expander.sv
// Grid neighbor expander: occupancy/cost stores and 8-neighbor successor generator.
// Load items write the stores at acceptance.
// An expand item whose index lies in the grid runs, in order:
// a bit-serial divide for the parent column/row, one neighbor memory read per cycle,
// a 3-stage read/sum/multiply pipe, then the final push. Results leave via a 16-entry queue.
// Reset (synchronous) restores config registers and clears control; memory contents stay.
module grid_neighbor_expander #(
  parameter int MAX_CELLS     = 65536,
  parameter int MAX_COST_MAPS = 4,
  parameter int MAX_SIDE      = 256
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // cell_index[15:0], cell_value[23:16]
  input  logic [3:0]  s_tuser,   // mode[1:0], map_select[3:2]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // neighbor_index[15:0], neighbor_x[23:16], neighbor_y[31:24],
                                 // direction[34:32], distance_q16[59:35], cost_q16[76:60]
  output logic        m_tuser,   // found
  output logic        m_tlast    // last
);

  import gne_pkg::*;

  localparam int AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CW   = $clog2(MAX_SIDE);
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int DSW  = (IDX_W > SW + CW) ? IDX_W : SW + CW;
  localparam int NW   = IDX_W + 1;
  localparam int CNTW = $clog2((CW > 8) ? CW : 8);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // ---------------------------------------------------------------- config
  logic [SIDE_W-1:0] grid_width;
  logic [SIDE_W-1:0] grid_height;
  logic [VAL_W-1:0]  occupied_min;
  logic [VAL_W-1:0]  occupied_max;
  logic [SIZE_W-1:0] cell_size_q16;
  logic [MAPS_W-1:0] active_maps;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= SIDE_W'(256);
      grid_height   <= SIDE_W'(256);
      occupied_min  <= VAL_W'(10);
      occupied_max  <= VAL_W'(255);
      cell_size_q16 <= SIZE_W'(65536);
      active_maps   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_GRID_WIDTH:   grid_width    <= pwdata[SIDE_W-1:0];
        REG_GRID_HEIGHT:  grid_height   <= pwdata[SIDE_W-1:0];
        REG_OCCUPIED_MIN: occupied_min  <= pwdata[VAL_W-1:0];
        REG_OCCUPIED_MAX: occupied_max  <= pwdata[VAL_W-1:0];
        REG_CELL_SIZE:    cell_size_q16 <= pwdata[SIZE_W-1:0];
        REG_ACTIVE_MAPS:  active_maps   <= pwdata[MAPS_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_GRID_WIDTH:   prdata = 32'(grid_width);
      REG_GRID_HEIGHT:  prdata = 32'(grid_height);
      REG_OCCUPIED_MIN: prdata = 32'(occupied_min);
      REG_OCCUPIED_MAX: prdata = 32'(occupied_max);
      REG_CELL_SIZE:    prdata = 32'(cell_size_q16);
      REG_ACTIVE_MAPS:  prdata = 32'(active_maps);
      default:          prdata = '0;
    endcase
  end

  // effective grid size and map count
  logic [SW-1:0]     w_eff;
  logic [SW-1:0]     h_eff;
  logic [2*SW-1:0]   grid_cells;
  logic [NMAP_W-1:0] n_eff;

  always_comb begin
    if (grid_width == '0)                w_eff = SW'(1);
    else if (grid_width > MAX_SIDE)      w_eff = SW'(MAX_SIDE);
    else                                 w_eff = SW'(grid_width);
    if (grid_height == '0)               h_eff = SW'(1);
    else if (grid_height > MAX_SIDE)     h_eff = SW'(MAX_SIDE);
    else                                 h_eff = SW'(grid_height);
    if (active_maps > MAX_COST_MAPS)     n_eff = NMAP_W'(MAX_COST_MAPS);
    else                                 n_eff = NMAP_W'(active_maps);
  end

  assign grid_cells = (2*SW)'(w_eff) * (2*SW)'(h_eff);

  // diagonal edge length, rounded half up
  logic [55:0]       diag_full;
  logic [DIST_W-1:0] diag_q16;

  assign diag_full = 56'(cell_size_q16) * 56'(SQRT2_Q30) + (56'd1 << 29);

  always_ff @(posedge clk) begin
    diag_q16 <= diag_full[54:30];
  end

  // ---------------------------------------------------------------- input
  logic [IDX_W-1:0] in_index;
  logic [VAL_W-1:0] in_value;
  logic [1:0]       in_mode;
  logic [1:0]       in_map;
  logic             in_accept;
  logic [31:0]      in_index32;
  logic             fifo_room;
  state_t           state;

  assign in_index   = s_tdata[15:0];
  assign in_value   = s_tdata[23:16];
  assign in_mode    = s_tuser[1:0];
  assign in_map     = s_tuser[3:2];
  assign in_index32 = 32'(in_index);
  assign s_tready   = (state == ST_IDLE) && fifo_room;
  assign in_accept  = s_tvalid && s_tready;

  // ---------------------------------------------------------------- sequencer
  logic [CNTW-1:0]  cnt;
  logic [DSW-1:0]   div_rem;
  logic [DSW-1:0]   div_dsh;
  logic [CW-1:0]    div_quo;
  logic             div_ge;
  logic [IDX_W-1:0] parent_idx;

  assign div_ge = (div_rem >= div_dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept && in_mode == MODE_EXPAND) begin
            parent_idx <= in_index;
            div_rem    <= DSW'(in_index);
            div_dsh    <= DSW'(w_eff) << (CW - 1);
            cnt        <= '0;
            state      <= (in_index < grid_cells) ? ST_DIVIDE : ST_FINISH;
          end
        end
        ST_DIVIDE: begin
          // one quotient bit per cycle
          div_rem <= div_ge ? div_rem - div_dsh : div_rem;
          div_dsh <= div_dsh >> 1;
          div_quo <= CW'({div_quo, div_ge});
          if (cnt == CNTW'(CW - 1)) begin
            cnt   <= '0;
            state <= ST_SCAN;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        ST_SCAN: begin
          if (cnt == CNTW'(7)) begin
            cnt   <= '0;
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        ST_DRAIN: begin
          if (cnt == CNTW'(2)) begin
            cnt   <= '0;
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- neighbor issue
  logic [2:0]    dir;
  logic [CW-1:0] px;
  logic [CW-1:0] py;
  logic [SW-1:0] px_ext;
  logic [SW-1:0] py_ext;
  logic          mv_left, mv_right, mv_up, mv_down;
  logic          inb;
  logic [CW-1:0] nx;
  logic [CW-1:0] ny;
  logic [NW-1:0] nidx;
  logic [31:0]   nidx32;
  logic          in_store;
  logic          issue;

  assign dir      = cnt[2:0];
  assign px       = div_rem[CW-1:0];
  assign py       = div_quo;
  assign px_ext   = SW'(px);
  assign py_ext   = SW'(py);
  assign mv_left  = DIR_LEFT[dir];
  assign mv_right = DIR_RIGHT[dir];
  assign mv_up    = DIR_UP[dir];
  assign mv_down  = DIR_DOWN[dir];

  assign inb = !(mv_left && px == '0) && !(mv_right && (px_ext + SW'(1)) == w_eff) &&
               !(mv_up && py == '0) && !(mv_down && (py_ext + SW'(1)) == h_eff);

  assign nx = px + CW'(mv_right) - CW'(mv_left);
  assign ny = py + CW'(mv_down) - CW'(mv_up);

  // neighbor index from the parent, no multiply
  assign nidx = NW'(parent_idx) + (mv_down ? NW'(w_eff) : '0) - (mv_up ? NW'(w_eff) : '0)
              + NW'(mv_right) - NW'(mv_left);
  assign nidx32   = 32'(nidx);
  assign in_store = (nidx32 < MAX_CELLS);
  assign issue    = (state == ST_SCAN) && inb;

  // ---------------------------------------------------------------- stores
  logic [AW-1:0]    ld_addr;
  logic [AW-1:0]    rd_addr;
  logic             ld_ok;
  logic [VAL_W-1:0] occ_rd;
  logic [VAL_W-1:0] cost_rd [MAX_COST_MAPS];

  assign ld_addr = in_index32[AW-1:0];
  assign rd_addr = nidx32[AW-1:0];
  assign ld_ok   = (in_index32 < MAX_CELLS);

  gne_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_CELLS)
  ) u_occ_ram (
    .clk     (clk),
    .wr_en   (in_accept && in_mode == MODE_LOAD_OCC && ld_ok),
    .wr_addr (ld_addr),
    .wr_data (in_value),
    .rd_en   (issue && in_store),
    .rd_addr (rd_addr),
    .rd_data (occ_rd)
  );

  // one bank per cost map, all read together
  for (genvar m = 0; m < MAX_COST_MAPS; m++) begin : g_cost
    gne_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_CELLS)
    ) u_cost_ram (
      .clk     (clk),
      .wr_en   (in_accept && in_mode == MODE_LOAD_COST && ld_ok && 32'(in_map) == m),
      .wr_addr (ld_addr),
      .wr_data (in_value),
      .rd_en   (issue && in_store),
      .rd_addr (rd_addr),
      .rd_data (cost_rd[m])
    );
  end

  // ---------------------------------------------------------------- stage 1: memory read
  logic          p1_valid;
  logic [2:0]    p1_dir;
  logic [CW-1:0] p1_x;
  logic [CW-1:0] p1_y;
  logic [NW-1:0] p1_idx;
  logic          p1_store;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    p1_dir   <= dir;
    p1_x     <= nx;
    p1_y     <= ny;
    p1_idx   <= nidx;
    p1_store <= in_store;
  end

  // ---------------------------------------------------------------- stage 2: occupancy test, cost sum
  logic [VAL_W-1:0] occ;
  logic             free;
  logic [SUM_W-1:0] cost_sum;
  logic [SUM_W-1:0] half_den;
  logic [NUM_W-1:0] num;

  assign occ  = p1_store ? occ_rd : '0;
  assign free = !(occ >= occupied_min && occ <= occupied_max);

  always_comb begin
    cost_sum = '0;
    for (int m = 0; m < MAX_COST_MAPS; m++) begin
      if (p1_store && m < n_eff) begin
        cost_sum = cost_sum + SUM_W'(cost_rd[m]);
      end
    end
  end

  assign half_den = (SUM_W'(n_eff) * SUM_W'(255)) >> 1;
  assign num      = (NUM_W'(cost_sum) << 16) + NUM_W'(half_den);

  logic             p2_valid;
  logic [2:0]       p2_dir;
  logic [CW-1:0]    p2_x;
  logic [CW-1:0]    p2_y;
  logic [NW-1:0]    p2_idx;
  logic [NUM_W-1:0] p2_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid && free;
    end
  end

  always_ff @(posedge clk) begin
    p2_dir <= p1_dir;
    p2_x   <= p1_x;
    p2_y   <= p1_y;
    p2_idx <= p1_idx;
    p2_num <= num;
  end

  // ---------------------------------------------------------------- stage 3: reciprocal multiply
  logic                     p3_valid;
  logic [2:0]               p3_dir;
  logic [CW-1:0]            p3_x;
  logic [CW-1:0]            p3_y;
  logic [NW-1:0]            p3_idx;
  logic [NUM_W+RECIP_W-1:0] p3_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    p3_dir  <= p2_dir;
    p3_x    <= p2_x;
    p3_y    <= p2_y;
    p3_idx  <= p2_idx;
    p3_prod <= (NUM_W+RECIP_W)'(p2_num) * (NUM_W+RECIP_W)'(COST_RECIP[n_eff]);
  end

  // ---------------------------------------------------------------- result assembly
  result_t p3_res;

  always_comb begin
    p3_res.found          = 1'b1;
    p3_res.neighbor_index = p3_idx[IDX_W-1:0];
    p3_res.neighbor_x     = COORD_W'(p3_x);
    p3_res.neighbor_y     = COORD_W'(p3_y);
    p3_res.direction      = p3_dir;
    p3_res.distance_q16   = DIR_STRAIGHT[p3_dir] ? DIST_W'(cell_size_q16) : diag_q16;
    p3_res.cost_q16       = p3_prod[COST_SHIFT +: COST_W];
    p3_res.last           = 1'b0;
  end

  // last result is held back until the next one shows up or the expand reaches its finish state
  result_t pend;
  logic    have_pend;
  result_t push_item;
  logic    push;
  logic    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend <= 1'b0;
    end else if (p3_valid) begin
      have_pend <= 1'b1;
    end else if (state == ST_FINISH) begin
      have_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_valid) begin
      pend <= p3_res;
    end
  end

  always_comb begin
    push_item = pend;
    push      = 1'b0;
    if (state == ST_FINISH) begin
      push = 1'b1;
      if (have_pend) begin
        push_item.last = 1'b1;
      end else begin
        push_item      = '0;
        push_item.last = 1'b1;
      end
    end else if (p3_valid && have_pend) begin
      push = 1'b1;
    end
  end

  // ---------------------------------------------------------------- output queue
  result_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] fifo_count;
  result_t            head;

  assign pop       = m_tvalid && m_tready;
  // an expand may push up to eight items
  assign fifo_room = (fifo_count <= FIFO_CW'(FIFO_DEPTH - 8));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_item;
    end
  end

  assign head     = fifo_mem[rd_ptr];
  assign m_tvalid = (fifo_count != '0);
  assign m_tuser  = head.found;
  assign m_tlast  = head.last;
  assign m_tdata  = {3'b000, head.cost_q16, head.distance_q16, head.direction,
                     head.neighbor_y, head.neighbor_x, head.neighbor_index};

  // ---------------------------------------------------------------- checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> fifo_count < FIFO_CW'(FIFO_DEPTH))
    else $error("push into full result queue");

  a_finish_push: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |=> !have_pend)
    else $error("held result survived end of expand");

  a_pipe_window: assert property (@(posedge clk) disable iff (rst)
    p3_valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("neighbor result outside scan window");

endmodule

>>> rtl/gne_ram.sv
// Generic simple dual-port RAM with registered read.
module gne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
